[rtl/atbp_pkg.sv]
// ----------------------------------------------------------------------------
// atbp_pkg
// Types and constants shared by the terminal byte parser modules.
// ----------------------------------------------------------------------------
package atbp_pkg;

  localparam int MAX_SLOTS = 8;

  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_PRINT    = 8'h20;

  typedef enum logic [2:0] {
    REG_LINE_WRAP     = 3'd0,
    REG_SCROLL_ENABLE = 3'd1,
    REG_AUTO_CR       = 3'd2,
    REG_AUTO_LF       = 3'd3,
    REG_HOME_CODE     = 3'd4,
    REG_CLEAR_CODE    = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_CHAR   = 3'd0,
    KIND_SCROLL = 3'd1,
    KIND_CLEAR  = 3'd2,
    KIND_PARAM  = 3'd3,
    KIND_CMD    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SCROLL = 2'd2,
    OP_CSI    = 2'd3
  } op_t;

  typedef struct packed {
    logic       line_wrap;
    logic       scroll_enable;
    logic       auto_cr;
    logic       auto_lf;
    logic [4:0] home_code;
    logic [4:0] clear_code;
  } cfg_t;

  typedef struct packed {
    op_t                       op;
    logic                      scroll;
    logic [7:0]                code;
    logic [6:0]                col;
    logic [4:0]                row;
    logic [6:0]                cur_col;
    logic [4:0]                cur_row;
    logic [2:0]                last_idx;
    logic [MAX_SLOTS-1:0][7:0] params;
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] code;
    logic [7:0] pval;
    logic [6:0] cur_col;
    logic [4:0] cur_row;
    logic       last;
  } res_t;

endpackage

[rtl/atbp_front.sv]
// ----------------------------------------------------------------------------
// atbp_front
// Accepts bytes, runs the escape parser and the cursor, and queues commands.
// ----------------------------------------------------------------------------
module atbp_front #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 30,
  parameter int PARAM_SLOTS = 8,
  parameter int FONT_LAST   = 127
) (
  input  logic          clk,
  input  logic          rst,
  input  atbp_pkg::cfg_t cfg,
  input  logic          push,
  input  logic [7:0]    ch,
  input  logic          q_full,
  output logic          q_push,
  output atbp_pkg::cmd_t q_wdata
);
  import atbp_pkg::*;

  localparam int IdxW = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;
  localparam logic signed [8:0] ColLast  = 9'(COLUMNS - 1);
  localparam logic signed [8:0] ColCount = 9'(COLUMNS);
  localparam logic signed [6:0] RowLast  = 7'(ROWS - 1);
  localparam logic [IdxW-1:0]   IdxLast  = IdxW'(PARAM_SLOTS - 1);
  localparam logic [7:0]        FontLast = 8'(FONT_LAST);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_CSI   = 2'd2
  } mode_t;

  mode_t                       mode, mode_next;
  logic [6:0]                  ccol;
  logic [4:0]                  crow;
  logic [PARAM_SLOTS-1:0][7:0] slots, slots_next;
  logic [IdxW-1:0]             idx, idx_next;

  logic              acc;
  logic              mv_req, head_en;
  op_t               head_op;
  logic signed [8:0] mx, fx;
  logic signed [6:0] my, fy;
  logic              mv_ok, mv_scr;
  logic [6:0]        col_next;
  logic [4:0]        row_next;
  logic [7:0]        slot_cur, digit, slot_acc, font_ch;

  assign acc      = push && !q_full;
  assign slot_cur = slots[idx];
  assign digit    = ch - CH_ZERO;
  assign slot_acc = {slot_cur[4:0], 3'b000} + {slot_cur[6:0], 1'b0} + {4'b0000, digit[3:0]};
  assign font_ch  = (ch <= FontLast) ? ch : CH_SPACE;

  always_comb begin
    mode_next  = mode;
    slots_next = slots;
    idx_next   = idx;
    mv_req     = 1'b0;
    head_en    = 1'b0;
    head_op    = OP_WRITE;
    mx         = $signed({2'b00, ccol});
    my         = $signed({2'b00, crow});
    if (ch == CH_ESC) begin
      mode_next = MODE_ESC;
    end else if (ch < CH_PRINT) begin
      if (ch == CH_BS) begin
        mv_req = 1'b1;
        mx     = $signed({2'b00, ccol}) - 9'sd1;
      end else if (ch == CH_CR) begin
        mv_req = 1'b1;
        mx     = '0;
        my     = $signed({2'b00, crow}) + $signed({6'd0, cfg.auto_lf});
      end else if (ch == CH_LF) begin
        mv_req = 1'b1;
        if (cfg.auto_cr) begin
          mx = '0;
        end
        my = $signed({2'b00, crow}) + 7'sd1;
      end else if (ch[4:0] == cfg.home_code) begin
        mv_req = 1'b1;
        mx     = '0;
        my     = '0;
      end else if (ch[4:0] == cfg.clear_code) begin
        mv_req  = 1'b1;
        mx      = '0;
        my      = '0;
        head_en = 1'b1;
        head_op = OP_CLEAR;
      end
    end else begin
      case (mode)
        MODE_ESC: begin
          if (ch == CH_LBRACKET) begin
            slots_next = '0;
            idx_next   = '0;
            mode_next  = MODE_CSI;
          end else begin
            mode_next = MODE_PLAIN;
          end
        end
        MODE_CSI: begin
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            slots_next[idx] = slot_acc;
          end else if (ch == CH_SEMI) begin
            if (idx != IdxLast) begin
              idx_next = idx + 1'b1;
            end
          end else begin
            head_en   = 1'b1;
            head_op   = OP_CSI;
            mode_next = MODE_PLAIN;
          end
        end
        default: begin
          mode_next = MODE_PLAIN;
          head_en   = 1'b1;
          head_op   = OP_WRITE;
          mv_req    = 1'b1;
          mx        = $signed({2'b00, ccol}) + 9'sd1;
        end
      endcase
    end
  end

  always_comb begin
    fx     = mx;
    fy     = my;
    mv_ok  = 1'b1;
    mv_scr = 1'b0;
    if (fx > ColLast) begin
      if (!cfg.line_wrap) begin
        mv_ok = 1'b0;
      end else begin
        fx = fx - ColCount;
        fy = fy + 7'sd1;
      end
    end
    if (mv_ok && fy > RowLast) begin
      if (!cfg.scroll_enable) begin
        mv_ok = 1'b0;
      end else begin
        fy     = RowLast;
        mv_scr = 1'b1;
      end
    end
    if (fx < 9'sd0) begin
      fx = fx + ColCount;
      fy = fy - 7'sd1;
    end
    if (fy < 7'sd0) begin
      fy = '0;
    end
  end

  always_comb begin
    col_next = ccol;
    row_next = crow;
    if (mv_req && mv_ok) begin
      col_next = fx[6:0];
      row_next = fy[4:0];
    end
    q_wdata          = '0;
    q_wdata.op       = head_op;
    q_wdata.scroll   = mv_req && mv_scr;
    q_wdata.code     = (head_op == OP_WRITE) ? font_ch : ch;
    q_wdata.col      = ccol;
    q_wdata.row      = crow;
    q_wdata.cur_col  = col_next;
    q_wdata.cur_row  = row_next;
    q_wdata.last_idx = 3'(idx);
    q_push           = 1'b0;
    if (head_en) begin
      q_push = acc;
    end else if (mv_req && mv_scr) begin
      q_wdata.op = OP_SCROLL;
      q_push     = acc;
    end
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i < PARAM_SLOTS) begin
        q_wdata.params[i] = slots[i % PARAM_SLOTS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_PLAIN;
      ccol  <= '0;
      crow  <= '0;
      slots <= '0;
      idx   <= '0;
    end else if (acc) begin
      mode  <= mode_next;
      ccol  <= col_next;
      crow  <= row_next;
      slots <= slots_next;
      idx   <= idx_next;
    end
  end

endmodule

[rtl/atbp_queue.sv]
// ----------------------------------------------------------------------------
// atbp_queue
// Two-entry command queue between the parser front and the result back end.
// ----------------------------------------------------------------------------
module atbp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  atbp_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output atbp_pkg::cmd_t rdata,
  output logic           empty
);
  import atbp_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/atbp_back.sv]
// ----------------------------------------------------------------------------
// atbp_back
// Expands each queued command into its result beats and holds the output.
// ----------------------------------------------------------------------------
module atbp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  atbp_pkg::cmd_t cmd,
  output logic           q_pop,
  input  logic           pop,
  output logic           out_valid,
  output atbp_pkg::res_t out_res
);
  import atbp_pkg::*;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  state_t     state;
  cmd_t       cur;
  logic [3:0] cnt;
  res_t       res_n;
  logic       load;

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign load  = (state == ST_RUN) && (!out_valid || pop);

  always_comb begin
    res_n         = '0;
    res_n.cur_col = cur.cur_col;
    res_n.cur_row = cur.cur_row;
    res_n.last    = 1'b1;
    case (cur.op)
      OP_WRITE: begin
        if (cnt == 4'd0) begin
          res_n.kind = KIND_CHAR;
          res_n.col  = cur.col;
          res_n.row  = cur.row;
          res_n.code = cur.code;
          res_n.last = !cur.scroll;
        end else begin
          res_n.kind = KIND_SCROLL;
        end
      end
      OP_CLEAR:  res_n.kind = KIND_CLEAR;
      OP_SCROLL: res_n.kind = KIND_SCROLL;
      OP_CSI: begin
        if (cnt <= {1'b0, cur.last_idx}) begin
          res_n.kind = KIND_PARAM;
          res_n.pval = cur.params[cnt[2:0]];
          res_n.last = 1'b0;
        end else begin
          res_n.kind = KIND_CMD;
          res_n.code = cur.code;
        end
      end
      default: res_n.kind = KIND_SCROLL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur   <= cmd;
            cnt   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (load) begin
            out_res <= res_n;
            if (res_n.last) begin
              state <= ST_IDLE;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/ansi_terminal_byte_parser_core.sv]
// ----------------------------------------------------------------------------
// ansi_terminal_byte_parser_core
// Terminal byte parser: cursor tracking, control codes and CSI sequences.
// ----------------------------------------------------------------------------
// Bytes enter through a queue-style port: a beat is taken when push is high
// and full is low. Results leave the same way: the oldest result sits on the
// result ports while empty is low and is taken when pop is high.
// Configuration is written on the cfg channel (cfg_ready is always high),
// with cfg_index selecting the register; write it only while the block is
// idle. A byte may yield no result, one, or several; last marks the final
// one of a byte.
// The front end parses a byte in the cycle it is taken and places a command
// in a two-entry queue. The back end loads a command while idle and then
// sends one result per cycle while the receiver keeps taking them; it loads
// the next command only after the last result. A printable byte yields a
// character result and, when it scrolls, a scroll result; a CSI final byte
// yields one parameter result per parameter and then a command result.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and full rises. Reset restores register defaults, homes the cursor,
// clears the parameters and empties the queue and output.
// ----------------------------------------------------------------------------
module ansi_terminal_byte_parser_core #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 30,
  parameter int PARAM_SLOTS = 8,
  parameter int FONT_LAST   = 127
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind,
  output logic [6:0] column,
  output logic [4:0] row,
  output logic [7:0] char_code,
  output logic [7:0] param_value,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_data
);
  import atbp_pkg::*;

  cfg_t cfg;
  logic q_push, q_full, q_pop, q_empty, out_valid;
  cmd_t q_wdata, q_rdata;
  res_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_wrap     <= 1'b1;
      cfg.scroll_enable <= 1'b1;
      cfg.auto_cr       <= 1'b1;
      cfg.auto_lf       <= 1'b1;
      cfg.home_code     <= 5'd30;
      cfg.clear_code    <= 5'd12;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_WRAP:     cfg.line_wrap     <= cfg_data[0];
        REG_SCROLL_ENABLE: cfg.scroll_enable <= cfg_data[0];
        REG_AUTO_CR:       cfg.auto_cr       <= cfg_data[0];
        REG_AUTO_LF:       cfg.auto_lf       <= cfg_data[0];
        REG_HOME_CODE:     cfg.home_code     <= cfg_data;
        REG_CLEAR_CODE:    cfg.clear_code    <= cfg_data;
        default:           cfg.line_wrap     <= cfg.line_wrap;
      endcase
    end
  end

  atbp_front #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .PARAM_SLOTS (PARAM_SLOTS),
    .FONT_LAST   (FONT_LAST)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .ch      (ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  atbp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  atbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .cmd       (q_rdata),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign full        = q_full;
  assign empty       = !out_valid;
  assign kind        = out_res.kind;
  assign column      = out_res.col;
  assign row         = out_res.row;
  assign char_code   = out_res.code;
  assign param_value = out_res.pval;
  assign cursor_col  = out_res.cur_col;
  assign cursor_row  = out_res.cur_row;
  assign last        = out_res.last;

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (cursor_col < COLUMNS) && (cursor_row < ROWS))
    else $error("cursor outside the screen");

  a_param_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_PARAM) |-> !last)
    else $error("CSI parameter beat marked last");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_SCROLL) |-> (cursor_row == 5'(ROWS - 1)))
    else $error("scroll beat with cursor off the bottom row");

endmodule
